// ===== design/ahd_pkg.sv =====
// ahd_pkg: shared types and constants for the audio to haptic derivation block
// item structs, register indexes, mode codes, filter coefficients
// no dependencies
`timescale 1ns / 1ps

package ahd_pkg;

    // input item: one four-channel sample frame
    typedef struct packed {
        logic signed [15:0] speaker_left;
        logic signed [15:0] speaker_right;
        logic signed [15:0] haptic_left;
        logic signed [15:0] haptic_right;
        logic               frame_last;
    } ahd_in_t;

    // result item
    typedef struct packed {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic [6:0]         derived_peak;
        logic               frame_done;
    } ahd_out_t;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_DRIVE_MODE     = 2'd0;
    localparam logic [1:0] REG_LOWPASS_SELECT = 2'd1;
    localparam logic [1:0] REG_AUTO_GAIN      = 2'd2;

    // drive mode codes
    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_FALLBACK = 2'd1;
    localparam logic [1:0] MODE_MIX      = 2'd2;
    localparam logic [1:0] MODE_REPLACE  = 2'd3;

    // register reset values
    localparam logic [1:0]  DRIVE_MODE_RST = MODE_FALLBACK;
    localparam logic [15:0] AUTO_GAIN_RST  = 16'd4096;

    // lowpass coefficients, unsigned Q0.16
    localparam logic [11:0] LP_COEF [4] = '{12'd681, 12'd1359, 12'd2028, 12'd3357};

    // envelope attack and release coefficients, unsigned Q0.16
    localparam logic [14:0] ENV_ATTACK  = 15'd26214;
    localparam logic [14:0] ENV_RELEASE = 15'd1638;

    // soft clip quotient width and step counter width
    localparam int QUOT_BITS = 15;
    localparam int CNT_W     = $clog2(QUOT_BITS + 1);

endpackage

// ===== design/audio_to_haptic_derivation.sv =====
// Audio to haptic derivation. One item is a four-channel frame (two speaker, two native
// haptic samples, Q1.15); one result item follows each. A small sequencer runs both
// channels through one shared signed multiplier (lowpass, envelope, drive magnitude,
// gain) and one 15-step divider for the x/(1+|x|) soft clips. A new item is taken only
// after the sequencer has finished the last one and handed its result to the result
// register. The divider runs once per channel when derived drive is applied, and a
// second time per channel in mix mode.
// in_ready is high only while the sequencer is idle; a finished result
// waits in an output register so the next item can be taken meanwhile.
// depends on ahd_pkg and ahd_div
`timescale 1ns / 1ps

module audio_to_haptic_derivation
    import ahd_pkg::*;
#(
    parameter int SILENCE_TIMEOUT = 100,
    parameter int NATIVE_LEVEL    = 256,
    parameter int STATE_FRAC_BITS = 23
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ahd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ahd_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int F  = STATE_FRAC_BITS;
    localparam int LW = F + 2;      // lowpass state, signed
    localparam int EW = F + 1;      // envelope state, unsigned
    localparam int MW = F + 4;      // multiplier operand width
    localparam int PW = F + 3;      // drive magnitude before gain
    localparam int QW = F + 6;      // drive magnitude after gain
    localparam int DW = F + 8;      // divider width

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_LP_MUL   = 13'b0000000000010,
        ST_LP_UPD   = 13'b0000000000100,
        ST_ENV_MUL  = 13'b0000000001000,
        ST_ENV_UPD  = 13'b0000000010000,
        ST_P_MUL    = 13'b0000000100000,
        ST_Q_MUL    = 13'b0000001000000,
        ST_DRV_GO   = 13'b0000010000000,
        ST_DRV_WAIT = 13'b0000100000000,
        ST_MIX_GO   = 13'b0001000000000,
        ST_MIX_WAIT = 13'b0010000000000,
        ST_NEXT     = 13'b0100000000000,
        ST_FIN      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [1:0]  drive_mode_reg;
    logic [1:0]  lowpass_select_reg;
    logic [15:0] auto_gain_reg;

    // filter and frame state
    logic signed [LW-1:0] lp_reg [2];
    logic [EW-1:0]        env_reg [2];
    logic [7:0]           silence_reg;
    logic [15:0]          native_peak_reg;
    logic [15:0]          applied_peak_reg;

    // working registers
    logic                 ch_reg;
    ahd_in_t              in_reg;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [15:0]   al_reg;
    logic signed [15:0]   drv_reg [2];
    logic                 sign_reg;
    logic                 out_valid_reg;
    ahd_out_t             out_reg;

    // datapath signals
    logic                 apply;
    logic                 cfg_wr;
    logic signed [15:0]   spk;
    logic signed [15:0]   hap;
    logic signed [LW-1:0] x_ch;
    logic signed [LW-1:0] lp_cur;
    logic [EW-1:0]        lp_mag;
    logic [EW-1:0]        env_cur;
    logic [14:0]          env_k;
    logic [PW-1:0]        env_scale;
    logic [PW-1:0]        p_val;
    logic [QW-1:0]        q_val;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [16:0]   mix_sum;
    logic [16:0]          mix_mag;
    logic                 div_start;
    logic [DW-1:0]        div_rem;
    logic [DW-1:0]        div_den;
    logic                 div_done;
    logic [QUOT_BITS-1:0] div_quot;
    logic signed [15:0]   quot_signed;
    logic [15:0]          hl_mag;
    logic [15:0]          hr_mag;
    logic [15:0]          native_next;
    logic [22:0]          peak_scaled;
    logic                 out_free;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg     <= DRIVE_MODE_RST;
            lowpass_select_reg <= '0;
            auto_gain_reg      <= AUTO_GAIN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DRIVE_MODE:     drive_mode_reg     <= pwdata[1:0];
                REG_LOWPASS_SELECT: lowpass_select_reg <= pwdata[1:0];
                REG_AUTO_GAIN:      auto_gain_reg      <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DRIVE_MODE:     prdata = {30'd0, drive_mode_reg};
            REG_LOWPASS_SELECT: prdata = {30'd0, lowpass_select_reg};
            REG_AUTO_GAIN:      prdata = {16'd0, auto_gain_reg};
            default:            prdata = '0;
        endcase
    end

    // derived drive is applied in mix/replace, or in fallback after long native silence
    assign apply = (drive_mode_reg == MODE_MIX) || (drive_mode_reg == MODE_REPLACE)
                || (silence_reg >= 8'(SILENCE_TIMEOUT));

    // per channel operand selection
    assign spk     = ch_reg ? in_reg.speaker_right : in_reg.speaker_left;
    assign hap     = ch_reg ? in_reg.haptic_right : in_reg.haptic_left;
    assign x_ch    = LW'(spk) <<< (F - 15);
    assign lp_cur  = lp_reg[ch_reg];
    assign env_cur = env_reg[ch_reg];
    assign lp_mag  = lp_cur[LW-1] ? EW'(-lp_cur) : EW'(lp_cur);
    assign env_k   = (lp_mag > env_cur) ? ENV_ATTACK : ENV_RELEASE;
    assign env_scale = (PW'(1) << F) + PW'(env_cur) + {env_cur, 1'b0};
    assign p_val   = prod_reg[2*F+2:F];
    assign q_val   = prod_reg[F+17:12];
    assign mix_sum = 17'(hap) + 17'(al_reg);
    assign mix_mag = mix_sum[16] ? 17'(-mix_sum) : 17'(mix_sum);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LP_MUL:
            begin
                mul_a = MW'(x_ch) - MW'(lp_cur);
                mul_b = MW'(signed'({1'b0, LP_COEF[lowpass_select_reg]}));
            end
            ST_ENV_MUL:
            begin
                mul_a = MW'(signed'({1'b0, lp_mag})) - MW'(signed'({1'b0, env_cur}));
                mul_b = MW'(signed'({1'b0, env_k}));
            end
            ST_P_MUL:
            begin
                mul_a = MW'(signed'({1'b0, lp_mag}));
                mul_b = signed'({1'b0, env_scale});
            end
            ST_Q_MUL:
            begin
                mul_a = signed'({1'b0, p_val});
                mul_b = MW'(signed'({1'b0, auto_gain_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // divider operands: derived soft clip or mix soft clip
    assign div_start = (state_reg == ST_DRV_GO) || (state_reg == ST_MIX_GO);
    assign div_rem   = (state_reg == ST_MIX_GO) ? DW'(mix_mag) : DW'(q_val);
    assign div_den   = (state_reg == ST_MIX_GO) ? DW'(mix_mag) + DW'(32768)
                                                : (DW'(1) << F) + DW'(q_val);

    ahd_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .divisor  (div_den),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign quot_signed = sign_reg ? -16'({1'b0, div_quot}) : 16'({1'b0, div_quot});

    // frame end bookkeeping
    assign hl_mag      = in_reg.haptic_left[15] ? 16'(-in_reg.haptic_left)
                                                : 16'(in_reg.haptic_left);
    assign hr_mag      = in_reg.haptic_right[15] ? 16'(-in_reg.haptic_right)
                                                 : 16'(in_reg.haptic_right);
    assign native_next = (hl_mag > native_peak_reg && hl_mag >= hr_mag) ? hl_mag
                       : (hr_mag > native_peak_reg) ? hr_mag : native_peak_reg;
    // peak times 127 as shift and subtract
    assign peak_scaled = {applied_peak_reg, 7'd0} - {7'd0, applied_peak_reg};
    assign out_free    = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (drive_mode_reg == MODE_OFF) ? ST_FIN : ST_LP_MUL;
            ST_LP_MUL:   state_next = ST_LP_UPD;
            ST_LP_UPD:   state_next = ST_ENV_MUL;
            ST_ENV_MUL:  state_next = ST_ENV_UPD;
            ST_ENV_UPD:  state_next = apply ? ST_P_MUL : ST_NEXT;
            ST_P_MUL:    state_next = ST_Q_MUL;
            ST_Q_MUL:    state_next = ST_DRV_GO;
            ST_DRV_GO:   state_next = ST_DRV_WAIT;
            ST_DRV_WAIT:
                if (div_done)
                    state_next = (drive_mode_reg == MODE_MIX) ? ST_MIX_GO : ST_NEXT;
            ST_MIX_GO:   state_next = ST_MIX_WAIT;
            ST_MIX_WAIT:
                if (div_done)
                    state_next = ST_NEXT;
            ST_NEXT:     state_next = ch_reg ? ST_FIN : ST_LP_MUL;
            ST_FIN:
                if (out_free)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ch_reg           <= 1'b0;
            lp_reg[0]        <= '0;
            lp_reg[1]        <= '0;
            env_reg[0]       <= '0;
            env_reg[1]       <= '0;
            silence_reg      <= 8'(2 * SILENCE_TIMEOUT);
            native_peak_reg  <= '0;
            applied_peak_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // result register: filled at finish, emptied when taken
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    ch_reg <= 1'b0;
                ST_LP_UPD:
                    lp_reg[ch_reg] <= lp_cur + LW'(prod_reg >>> 16);
                ST_ENV_UPD:
                    env_reg[ch_reg] <= EW'(MW'(signed'({1'b0, env_cur}))
                                           + MW'(prod_reg >>> 16));
                ST_DRV_WAIT:
                    if (div_done && (16'(div_quot) > applied_peak_reg))
                        applied_peak_reg <= 16'(div_quot);
                ST_NEXT:
                    ch_reg <= 1'b1;
                ST_FIN:
                    if (out_free)
                    begin
                        if (in_reg.frame_last)
                        begin
                            if (native_next > 16'(NATIVE_LEVEL))
                                silence_reg <= '0;
                            else if (silence_reg < 8'(2 * SILENCE_TIMEOUT))
                                silence_reg <= silence_reg + 8'd1;
                            native_peak_reg  <= '0;
                            applied_peak_reg <= '0;
                        end
                        else
                        begin
                            native_peak_reg <= native_next;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

    // item payload and drive values
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg     <= in_data;
            drv_reg[0] <= in_data.haptic_left;
            drv_reg[1] <= in_data.haptic_right;
        end
        if (state_reg == ST_DRV_GO)
            sign_reg <= lp_cur[LW-1];
        if (state_reg == ST_MIX_GO)
            sign_reg <= mix_sum[16];
        if (state_reg == ST_DRV_WAIT && div_done)
        begin
            al_reg <= quot_signed;
            if (drive_mode_reg != MODE_MIX)
                drv_reg[ch_reg] <= quot_signed;
        end
        if (state_reg == ST_MIX_WAIT && div_done)
            drv_reg[ch_reg] <= quot_signed;
        if (state_reg == ST_FIN && out_free)
        begin
            out_reg.drive_left   <= drv_reg[0];
            out_reg.drive_right  <= drv_reg[1];
            out_reg.derived_peak <= in_reg.frame_last ? peak_scaled[21:15] : 7'd0;
            out_reg.frame_done   <= in_reg.frame_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while another is in progress");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DRV_WAIT) || (state_reg == ST_MIX_WAIT))
        else $error("divider result arrived outside a wait state");

    a_env_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (env_reg[0] <= (EW'(1) << F)) && (env_reg[1] <= (EW'(1) << F)))
        else $error("envelope out of range");

    a_silence_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        silence_reg <= 8'(2 * SILENCE_TIMEOUT))
        else $error("silence counter past saturation");

endmodule

// ===== design/ahd_div.sv =====
// ahd_div: iterative restoring divider, one quotient bit per cycle
// computes floor(rem_init * 2^15 / divisor), valid when rem_init < divisor
// depends on ahd_pkg
`timescale 1ns / 1ps

module ahd_div
    import ahd_pkg::*;
#(
    parameter int DW = 31
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        rem_init,
    input  logic [DW-1:0]        divisor,
    output logic                 done,
    output logic [QUOT_BITS-1:0] quot
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        div_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [DW:0]          rem_sh;
    logic                 ge;

    // one long division step
    assign rem_sh = {rem_reg, 1'b0};
    assign ge     = rem_sh >= {1'b0, div_reg};

    // step counter control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            div_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? DW'(rem_sh - {1'b0, div_reg}) : DW'(rem_sh);
            quot_reg <= {quot_reg[QUOT_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for audio_to_haptic_derivation
// directed table then randomized bursts, checked against an in-bench drive predictor
// depends on ahd_pkg and the design sources
`timescale 1ns / 1ps

module tb_top;
    import ahd_pkg::*;

    localparam int       SILENCE_TIMEOUT = 100;
    localparam int       NATIVE_LEVEL    = 256;
    localparam int       FRAC            = 23;
    localparam int       PHASE_ITEMS     = 240;
    localparam int       RAND_PHASES     = 8;
    localparam realtime  RUN_LIMIT       = 30ms;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    ahd_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    ahd_out_t    out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    audio_to_haptic_derivation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // directed stimulus row: settings in force, item, optional hand-written result
    typedef struct {
        logic [1:0]  mode;
        logic [1:0]  lp_sel;
        logic [15:0] gain;
        ahd_in_t     item;
        bit          has_exp;
        ahd_out_t    exp_out;
    } row_t;

    // predictor state and shadow registers
    logic [1:0]  cfg_mode;
    logic [1:0]  cfg_lp_sel;
    logic [15:0] cfg_gain;
    longint      lp_state [2];
    longint      env_state [2];
    int          quiet_frames;
    int          native_hi;
    int          derived_max;

    ahd_out_t    expected_drive [$];
    int          fail_count;
    int          items_sent;
    int          results_seen;
    int          frames_closed;
    int          mode_items [4];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout: %0d results still expected", expected_drive.size());
        $display("** audio_to_haptic_derivation: FAILED **");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // one-pole lowpass then attack/release envelope, one channel
    function automatic void filter_step(int c, int spk);
        longint x;
        longint mag;
        longint k;
        x = longint'(spk) * 256;
        lp_state[c] += (longint'(LP_COEF[cfg_lp_sel]) * (x - lp_state[c])) >>> 16;
        mag = lp_state[c] < 0 ? -lp_state[c] : lp_state[c];
        k = (mag > env_state[c]) ? longint'(ENV_ATTACK) : longint'(ENV_RELEASE);
        env_state[c] += (k * (mag - env_state[c])) >>> 16;
    endfunction

    // derived Q15 drive: lp*(1+3*env)*gain, soft clipped
    function automatic int derive_drive(longint lp, longint env);
        longint unsigned one;
        longint unsigned mag;
        longint unsigned p;
        longint unsigned q;
        int y;
        one = longint'(1) << FRAC;
        mag = lp < 0 ? -lp : lp;
        p = (mag * (one + 3 * env)) >> FRAC;
        q = (p * cfg_gain) >> 12;
        y = int'((q << 15) / (one + q));
        return lp < 0 ? -y : y;
    endfunction

    function automatic int soft_limit(int v);
        longint m;
        int y;
        m = v < 0 ? -v : v;
        y = int'((m << 15) / (32768 + m));
        return v < 0 ? -y : y;
    endfunction

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int clamp15(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // expected result for one accepted item, advances the predictor state
    function automatic ahd_out_t predict_drive(ahd_in_t it);
        ahd_out_t r;
        int h [2];
        int a [2];
        int peak;
        bit apply;
        h[0] = $signed(it.haptic_left);
        h[1] = $signed(it.haptic_right);
        peak = 0;
        for (int c = 0; c < 2; c++)
        begin
            if (iabs(h[c]) > native_hi) native_hi = iabs(h[c]);
        end
        if (cfg_mode != MODE_OFF)
        begin
            filter_step(0, $signed(it.speaker_left));
            filter_step(1, $signed(it.speaker_right));
            apply = (cfg_mode == MODE_MIX) || (cfg_mode == MODE_REPLACE)
                    || (quiet_frames >= SILENCE_TIMEOUT);
            for (int c = 0; c < 2; c++)
            begin
                a[c] = derive_drive(lp_state[c], env_state[c]);
                if (apply)
                begin
                    h[c] = (cfg_mode == MODE_MIX) ? soft_limit(h[c] + a[c]) : a[c];
                    if (iabs(a[c]) > derived_max) derived_max = iabs(a[c]);
                end
            end
        end
        if (it.frame_last)
        begin
            peak = (derived_max * 127) >>> 15;
            if (peak > 127) peak = 127;
            if (native_hi > NATIVE_LEVEL)
                quiet_frames = 0;
            else if (quiet_frames < 2 * SILENCE_TIMEOUT)
                quiet_frames++;
            native_hi = 0;
            derived_max = 0;
        end
        r.drive_left   = 16'(clamp15(h[0]));
        r.drive_right  = 16'(clamp15(h[1]));
        r.derived_peak = 7'(peak);
        r.frame_done   = it.frame_last;
        return r;
    endfunction

    function automatic ahd_in_t mk_in(int sl, int sr, int hl, int hr, bit last);
        ahd_in_t it;
        it.speaker_left  = 16'(sl);
        it.speaker_right = 16'(sr);
        it.haptic_left   = 16'(hl);
        it.haptic_right  = 16'(hr);
        it.frame_last    = last;
        return it;
    endfunction

    function automatic ahd_out_t mk_out(int dl, int dr, int pk, bit done);
        ahd_out_t r;
        r.drive_left   = 16'(dl);
        r.drive_right  = 16'(dr);
        r.derived_peak = 7'(pk);
        r.frame_done   = done;
        return r;
    endfunction

    // register write: setup then access cycle
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_DRIVE_MODE:     cfg_mode   = value[1:0];
            REG_LOWPASS_SELECT: cfg_lp_sel = value[1:0];
            default:            cfg_gain   = value[15:0];
        endcase
    endtask

    // hold off until every expected result has come and the block is idle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(logic [1:0] mode, logic [1:0] lp_sel, logic [15:0] gain);
        drain();
        write_reg(REG_DRIVE_MODE, {30'd0, mode});
        write_reg(REG_LOWPASS_SELECT, {30'd0, lp_sel});
        write_reg(REG_AUTO_GAIN, {16'd0, gain});
    endtask

    // present one item and hold it until accepted; valid stays high afterwards
    task automatic send_frame(ahd_in_t it, bit has_exp, ahd_out_t exp_out);
        ahd_out_t p;
        @(negedge clk);
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        p = predict_drive(it);
        expected_drive.push_back(has_exp ? exp_out : p);
        items_sent++;
        mode_items[cfg_mode]++;
    endtask

    // sender gap after an item: zero keeps the burst going
    task automatic sender_gap(int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // receiver stall pattern
    initial
    begin
        int style;
        int cnt;
        style = 0;
        cnt = 0;
        forever
        begin
            @(negedge clk);
            if (cnt == 0)
            begin
                style = $urandom_range(0, 3);
                cnt = $urandom_range(16, 200);
            end
            cnt--;
            case (style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((cnt % 7) < 4);
            endcase
        end
    end

    // result checking
    always @(posedge clk)
    begin
        ahd_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.frame_done) frames_closed++;
            if (expected_drive.size() == 0)
            begin
                report_mismatch("unexpected results", 1, 0);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (out_data.drive_left !== want.drive_left)
                    report_mismatch("drive_left", $signed(out_data.drive_left),
                                    $signed(want.drive_left));
                if (out_data.drive_right !== want.drive_right)
                    report_mismatch("drive_right", $signed(out_data.drive_right),
                                    $signed(want.drive_right));
                if (out_data.derived_peak !== want.derived_peak)
                    report_mismatch("derived_peak", out_data.derived_peak,
                                    want.derived_peak);
                if (out_data.frame_done !== want.frame_done)
                    report_mismatch("frame_done", out_data.frame_done, want.frame_done);
            end
        end
    end

    // stimulus
    initial
    begin
        row_t    rows [$];
        ahd_in_t it;
        int      spk [2];
        int      burst;
        int      wait_cycles;
        bit      loud;
        logic [1:0]  ph_mode;
        logic [1:0]  ph_sel;
        logic [15:0] ph_gain;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cfg_mode   = DRIVE_MODE_RST;
        cfg_lp_sel = 2'd0;
        cfg_gain   = AUTO_GAIN_RST;
        for (int c = 0; c < 2; c++)
        begin
            lp_state[c]  = 0;
            env_state[c] = 0;
        end
        quiet_frames = 2 * SILENCE_TIMEOUT;
        native_hi    = 0;
        derived_max  = 0;
        fail_count   = 0;
        items_sent   = 0;
        results_seen = 0;
        frames_closed = 0;
        for (int m = 0; m < 4; m++) mode_items[m] = 0;

        // directed table
        // after reset: silent input in fallback gives zero drive
        rows.push_back('{MODE_FALLBACK, 2'd0, 16'd4096, mk_in(0, 0, 0, 0, 1), 1,
                         mk_out(0, 0, 0, 1)});
        rows.push_back('{MODE_FALLBACK, 2'd0, 16'd4096, mk_in(32767, -32768, 0, 0, 0), 0,
                         mk_out(0, 0, 0, 0)});
        // loud native haptics close the frame and reset the silence counter
        rows.push_back('{MODE_FALLBACK, 2'd0, 16'd4096,
                         mk_in(-32768, 32767, -32768, 32767, 1), 0, mk_out(0, 0, 0, 0)});
        // fallback now idle: haptics pass through
        rows.push_back('{MODE_FALLBACK, 2'd0, 16'd4096, mk_in(32767, 32767, 100, -100, 1), 1,
                         mk_out(100, -100, 0, 1)});
        // mode off passes haptics, full-scale negative included
        rows.push_back('{MODE_OFF, 2'd1, 16'd4096, mk_in(32767, 32767, -32768, 32767, 0), 1,
                         mk_out(-32768, 32767, 0, 0)});
        rows.push_back('{MODE_OFF, 2'd1, 16'd4096, mk_in(-32768, 0, 5, -5, 1), 1,
                         mk_out(5, -5, 0, 1)});
        // replace at maximum gain with lowpass select 3, then with lowpass select 2 at reset gain
        rows.push_back('{MODE_REPLACE, 2'd3, 16'hFFFF, mk_in(32767, -32768, 0, 0, 0), 0,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_REPLACE, 2'd3, 16'hFFFF, mk_in(32767, -32768, 0, 0, 0), 0,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_REPLACE, 2'd3, 16'hFFFF, mk_in(32767, -32768, 300, 0, 1), 0,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_REPLACE, 2'd2, 16'd4096, mk_in(-32768, 32767, 0, 0, 0), 0,
                         mk_out(0, 0, 0, 0)});
        // zero gain replaces with silence
        rows.push_back('{MODE_REPLACE, 2'd0, 16'd0, mk_in(32767, 32767, 1234, -1234, 0), 1,
                         mk_out(0, 0, 0, 0)});
        // mix: soft clip of native plus derived
        rows.push_back('{MODE_MIX, 2'd1, 16'hFFFF, mk_in(32767, 32767, 32767, 32767, 0), 0,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_MIX, 2'd1, 16'hFFFF,
                         mk_in(-32768, -32768, -32768, -32768, 1), 0, mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_MIX, 2'd2, 16'd0, mk_in(0, 0, -32768, 32767, 0), 0,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_MIX, 2'd2, 16'd0, mk_in(0, 0, 256, -256, 1), 0,
                         mk_out(0, 0, 0, 0)});
        rows.push_back('{MODE_FALLBACK, 2'd3, 16'd8192, mk_in(20000, -20000, 257, 0, 1), 0,
                         mk_out(0, 0, 0, 0)});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].mode != cfg_mode || rows[i].lp_sel != cfg_lp_sel
                || rows[i].gain != cfg_gain)
                apply_settings(rows[i].mode, rows[i].lp_sel, rows[i].gain);
            send_frame(rows[i].item, rows[i].has_exp, rows[i].exp_out);
            sender_gap($urandom_range(0, 2));
        end

        // random phases, each under its own settings
        spk[0] = 0;
        spk[1] = 0;
        loud = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            ph_mode = 2'(ph % 4);
            ph_sel  = (ph < 4) ? 2'(3 - ph) : 2'($urandom_range(0, 3));
            case (ph)
                0:       ph_gain = 16'hFFFF;
                1:       ph_gain = 16'd0;
                2:       ph_gain = AUTO_GAIN_RST;
                default: ph_gain = 16'($urandom_range(0, 65535));
            endcase
            if (ph == 5) ph_mode = MODE_FALLBACK;
            apply_settings(ph_mode, ph_sel, ph_gain);
            burst = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    case ($urandom_range(0, 5))
                        0:       spk[c] = $signed(16'($urandom));
                        1:       spk[c] = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                        default: spk[c] = clamp15(spk[c] + $urandom_range(0, 4000) - 2000);
                    endcase
                end
                it.speaker_left  = 16'(spk[0]);
                it.speaker_right = 16'(spk[1]);
                if (loud)
                begin
                    it.haptic_left  = 16'($urandom);
                    it.haptic_right = 16'($urandom);
                end
                else
                begin
                    it.haptic_left  = 16'($urandom_range(0, 514) - 257);
                    it.haptic_right = 16'($urandom_range(0, 514) - 257);
                end
                it.frame_last = ($urandom_range(0, 3) == 0);
                if (it.frame_last) loud = ($urandom_range(0, 7) == 0);
                send_frame(it, 0, mk_out(0, 0, 0, 0));
                // bursts with random gaps, now and then a long pause
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    sender_gap(($urandom_range(0, 15) == 0) ? $urandom_range(30, 120)
                                                            : $urandom_range(1, 6));
                end
                else
                    burst--;
            end
        end

        // wait out the remaining results
        @(negedge clk);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_drive.size() != 0 && wait_cycles < 50000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        if (expected_drive.size() != 0)
            report_mismatch("results outstanding", expected_drive.size(), 0);
        repeat (200) @(negedge clk);

        $display("covered %0d items, %0d results, %0d closed usb frames",
                 items_sent, results_seen, frames_closed);
        $display("items per mode: off %0d, fallback %0d, mix %0d, replace %0d",
                 mode_items[0], mode_items[1], mode_items[2], mode_items[3]);
        if (fail_count == 0)
            $display("** audio_to_haptic_derivation: PASSED **");
        else
            $display("** audio_to_haptic_derivation: FAILED **");
        $finish;
    end

endmodule
